// ----- rtl/core/iss_pkg.sv -----
// ----------------------------------------------------------------------------
// iss_pkg
// Shared sizes, codes and controller/datapath bundles of the indexed
// sequential search block.
// ----------------------------------------------------------------------------
package iss_pkg;

	localparam int PAGE_ITEMS = 8;
	localparam int MAX_PAGES  = 256;
	localparam int CAPACITY   = PAGE_ITEMS * MAX_PAGES;

	localparam int REC_AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PAGE_AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int ITEM_W  = (PAGE_ITEMS > 1) ? $clog2(PAGE_ITEMS) : 1;
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int PG_W    = $clog2(MAX_PAGES + 1);

	localparam int MODE_W  = 2;
	localparam int KEY_W   = 32;
	localparam int PRICE_W = 64;
	localparam int TLO_W   = 64;
	localparam int THI_W   = 56;
	localparam int STAT_W  = 3;
	localparam int NUM_W   = 11;

	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND = 2'd0,
		MODE_SEARCH = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_APPENDED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_CLEARED   = 3'd4
	} status_t;

	// one stored record, one RAM word
	typedef struct packed {
		logic [THI_W-1:0]          title_high;
		logic [TLO_W-1:0]          title_low;
		logic signed [PRICE_W-1:0] price;
		logic signed [KEY_W-1:0]   key;
	} rec_word_t;

	localparam int REC_W = $bits(rec_word_t);

	typedef struct packed {
		logic    load;
		logic    append;
		logic    clear;
		logic    search_start;
		logic    idx_step;
		logic    page_start;
		logic    rec_step;
		logic    res_set;
		status_t res_code;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              full;
		logic              idx_more;
		logic              pg_zero;
		logic              rec_more;
		logic              rec_hit;
	} sts_t;

endpackage

// ----- rtl/core/iss_if.sv -----
// ----------------------------------------------------------------------------
// iss_in_if / iss_out_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface iss_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [iss_pkg::MODE_W-1:0]           mode;
	logic signed [iss_pkg::KEY_W-1:0]     record_key;
	logic signed [iss_pkg::PRICE_W-1:0]   record_price;
	logic [iss_pkg::TLO_W-1:0]            title_low;
	logic [iss_pkg::THI_W-1:0]            title_high;

	modport source(output valid, mode, record_key, record_price, title_low, title_high,
		input ready);
	modport sink(input valid, mode, record_key, record_price, title_low, title_high,
		output ready);
endinterface

interface iss_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [iss_pkg::STAT_W-1:0]           status;
	logic signed [iss_pkg::PRICE_W-1:0]   found_price;
	logic [iss_pkg::TLO_W-1:0]            found_title_low;
	logic [iss_pkg::THI_W-1:0]            found_title_high;
	logic [iss_pkg::NUM_W-1:0]            record_number;

	modport source(output valid, status, found_price, found_title_low, found_title_high,
		record_number, input ready);
	modport sink(input valid, status, found_price, found_title_low, found_title_high,
		record_number, output ready);
endinterface

// ----- rtl/core/iss_ram.sv -----
// ----------------------------------------------------------------------------
// iss_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module iss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/iss_datapath.sv -----
// ----------------------------------------------------------------------------
// iss_datapath
// Record store, page index, fill counters, scan counters and result
// registers of the indexed sequential search block.
// ----------------------------------------------------------------------------
module iss_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  iss_pkg::cmd_t                        cmd,
	output iss_pkg::sts_t                        sts,
	input  logic [iss_pkg::MODE_W-1:0]           mode,
	input  logic signed [iss_pkg::KEY_W-1:0]     record_key,
	input  logic signed [iss_pkg::PRICE_W-1:0]   record_price,
	input  logic [iss_pkg::TLO_W-1:0]            title_low,
	input  logic [iss_pkg::THI_W-1:0]            title_high,
	output logic [iss_pkg::STAT_W-1:0]           status,
	output logic signed [iss_pkg::PRICE_W-1:0]   found_price,
	output logic [iss_pkg::TLO_W-1:0]            found_title_low,
	output logic [iss_pkg::THI_W-1:0]            found_title_high,
	output logic [iss_pkg::NUM_W-1:0]            record_number
);

	// latched request
	logic [iss_pkg::MODE_W-1:0]         mode_q;
	logic signed [iss_pkg::KEY_W-1:0]   key_q;
	logic signed [iss_pkg::PRICE_W-1:0] price_q;
	logic [iss_pkg::TLO_W-1:0]          tlo_q;
	logic [iss_pkg::THI_W-1:0]          thi_q;

	// store fill state
	logic [iss_pkg::CNT_W-1:0]   cnt_q;
	logic [iss_pkg::ITEM_W-1:0]  slot_q;
	logic [iss_pkg::PAGE_AW-1:0] page_q;

	// scan state
	logic [iss_pkg::PG_W-1:0]  pg_q;
	logic [iss_pkg::CNT_W-1:0] base_q;
	logic [iss_pkg::CNT_W-1:0] rec_q;
	logic [iss_pkg::CNT_W-1:0] end_q;

	// pending result and output register
	iss_pkg::status_t                   res_status_q;
	logic signed [iss_pkg::PRICE_W-1:0] res_price_q;
	logic [iss_pkg::TLO_W-1:0]          res_tlo_q;
	logic [iss_pkg::THI_W-1:0]          res_thi_q;
	logic [iss_pkg::NUM_W-1:0]          res_num_q;
	iss_pkg::status_t                   out_status_q;
	logic signed [iss_pkg::PRICE_W-1:0] out_price_q;
	logic [iss_pkg::TLO_W-1:0]          out_tlo_q;
	logic [iss_pkg::THI_W-1:0]          out_thi_q;
	logic [iss_pkg::NUM_W-1:0]          out_num_q;

	logic                        rec_we;
	logic                        idx_we;
	logic [iss_pkg::REC_AW-1:0]  rec_raddr;
	logic [iss_pkg::PAGE_AW-1:0] idx_raddr;
	logic [iss_pkg::CNT_W-1:0]   page_base;
	logic [iss_pkg::KEY_W-1:0]   idx_rdata;
	iss_pkg::rec_word_t          rec_wdata;
	iss_pkg::rec_word_t          rec_rdata;

	assign sts.mode     = mode_q;
	assign sts.full     = (cnt_q == iss_pkg::CNT_W'(iss_pkg::CAPACITY));
	assign sts.idx_more = (base_q < cnt_q) && ($signed(idx_rdata) <= key_q);
	assign sts.pg_zero  = (pg_q == '0);
	assign sts.rec_more = (rec_q < end_q);
	assign sts.rec_hit  = (rec_rdata.key == key_q);

	assign rec_we = cmd.append && !sts.full;
	assign idx_we = rec_we && (slot_q == '0);

	assign rec_wdata.key        = key_q;
	assign rec_wdata.price      = price_q;
	assign rec_wdata.title_low  = tlo_q;
	assign rec_wdata.title_high = thi_q;

	// base_q sits one page past the page that the index walk settles on
	assign page_base = base_q - iss_pkg::CNT_W'(iss_pkg::PAGE_ITEMS);

	// read one entry ahead so that each scan cycle compares fresh data
	assign idx_raddr = cmd.search_start ? '0 : iss_pkg::PAGE_AW'(pg_q + iss_pkg::PG_W'(1));
	assign rec_raddr = cmd.page_start ? iss_pkg::REC_AW'(page_base)
		: iss_pkg::REC_AW'(rec_q + iss_pkg::CNT_W'(1));

	iss_ram #(
		.WIDTH(iss_pkg::REC_W),
		.DEPTH(iss_pkg::CAPACITY)
	) u_rec_ram (
		.clk  (clk),
		.we   (rec_we),
		.waddr(iss_pkg::REC_AW'(cnt_q)),
		.wdata(rec_wdata),
		.raddr(rec_raddr),
		.rdata(rec_rdata)
	);

	iss_ram #(
		.WIDTH(iss_pkg::KEY_W),
		.DEPTH(iss_pkg::MAX_PAGES)
	) u_idx_ram (
		.clk  (clk),
		.we   (idx_we),
		.waddr(page_q),
		.wdata(key_q),
		.raddr(idx_raddr),
		.rdata(idx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			slot_q <= '0;
			page_q <= '0;
			pg_q   <= '0;
			base_q <= '0;
			rec_q  <= '0;
			end_q  <= '0;
		end else begin
			if (cmd.clear) begin
				cnt_q  <= '0;
				slot_q <= '0;
				page_q <= '0;
			end else if (rec_we) begin
				cnt_q <= cnt_q + iss_pkg::CNT_W'(1);
				if (slot_q == iss_pkg::ITEM_W'(iss_pkg::PAGE_ITEMS - 1)) begin
					slot_q <= '0;
					page_q <= page_q + iss_pkg::PAGE_AW'(1);
				end else begin
					slot_q <= slot_q + iss_pkg::ITEM_W'(1);
				end
			end
			if (cmd.search_start) begin
				pg_q   <= '0;
				base_q <= '0;
			end else if (cmd.idx_step) begin
				pg_q   <= pg_q + iss_pkg::PG_W'(1);
				base_q <= base_q + iss_pkg::CNT_W'(iss_pkg::PAGE_ITEMS);
			end
			if (cmd.page_start) begin
				rec_q <= page_base;
				// a page that is not the last holds PAGE_ITEMS records
				end_q <= (base_q < cnt_q) ? base_q : cnt_q;
			end else if (cmd.rec_step) begin
				rec_q <= rec_q + iss_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			key_q   <= record_key;
			price_q <= record_price;
			tlo_q   <= title_low;
			thi_q   <= title_high;
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_code;
			if (cmd.res_code == iss_pkg::ST_FOUND) begin
				res_price_q <= rec_rdata.price;
				res_tlo_q   <= rec_rdata.title_low;
				res_thi_q   <= rec_rdata.title_high;
				res_num_q   <= iss_pkg::NUM_W'(rec_q);
			end else begin
				res_price_q <= '0;
				res_tlo_q   <= '0;
				res_thi_q   <= '0;
				res_num_q   <= (cmd.res_code == iss_pkg::ST_APPENDED)
					? iss_pkg::NUM_W'(cnt_q) : '0;
			end
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_price_q  <= res_price_q;
			out_tlo_q    <= res_tlo_q;
			out_thi_q    <= res_thi_q;
			out_num_q    <= res_num_q;
		end
	end

	assign status           = out_status_q;
	assign found_price      = out_price_q;
	assign found_title_low  = out_tlo_q;
	assign found_title_high = out_thi_q;
	assign record_number    = out_num_q;

endmodule

// ----- rtl/core/iss_ctrl.sv -----
// ----------------------------------------------------------------------------
// iss_ctrl
// Sequencer of the indexed sequential search block: decodes a request,
// steps the index and page scans, and hands results to the output register.
// ----------------------------------------------------------------------------
module iss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output iss_pkg::cmd_t cmd,
	input  iss_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_IDX,
		S_REC,
		S_POST
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd      = '0;
		cmd.res_code = iss_pkg::ST_NOT_FOUND;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (sts.mode)
					iss_pkg::MODE_APPEND: begin
						cmd.append   = 1'b1;
						cmd.res_set  = 1'b1;
						cmd.res_code = sts.full ? iss_pkg::ST_FULL : iss_pkg::ST_APPENDED;
						state_d      = S_POST;
					end
					iss_pkg::MODE_SEARCH: begin
						cmd.search_start = 1'b1;
						state_d          = S_IDX;
					end
					iss_pkg::MODE_CLEAR: begin
						cmd.clear    = 1'b1;
						cmd.res_set  = 1'b1;
						cmd.res_code = iss_pkg::ST_CLEARED;
						state_d      = S_POST;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_IDX: begin
				priority if (sts.idx_more) begin
					cmd.idx_step = 1'b1;
				end else if (sts.pg_zero) begin
					// key below the first page, or store empty
					cmd.res_set  = 1'b1;
					cmd.res_code = iss_pkg::ST_NOT_FOUND;
					state_d      = S_POST;
				end else begin
					cmd.page_start = 1'b1;
					state_d        = S_REC;
				end
			end
			S_REC: begin
				priority if (!sts.rec_more) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = iss_pkg::ST_NOT_FOUND;
					state_d      = S_POST;
				end else if (sts.rec_hit) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = iss_pkg::ST_FOUND;
					state_d      = S_POST;
				end else begin
					cmd.rec_step = 1'b1;
				end
			end
			S_POST: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/indexed_sequential_search_top.sv -----
// ----------------------------------------------------------------------------
// indexed_sequential_search_top
// Paged record store with a first-key index; appends, searches by key and
// clears on request; each append, search or clear request gives one result.
// ----------------------------------------------------------------------------
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    mode, record_key, record_price, title_*
//   out_ch    out   valid/ready    status, found_*, record_number
//
// One request at a time. Append and clear: the request is latched, executed and
// its result loaded into the output register. Search: the index walk compares up
// to MAX_PAGES index keys, then the page scan up to PAGE_ITEMS page entries; a key
// below the first page skips the page scan. in_ready returns with the result's valid.
// Reset clears fill and scan state and output valid; store contents are never cleared.
// A finished result waits in the output register; a second one stalls until it goes.
// ----------------------------------------------------------------------------
module indexed_sequential_search_top (
	input logic        clk,
	input logic        arst_n,
	iss_in_if.sink     in_ch,
	iss_out_if.source  out_ch
);

	iss_pkg::cmd_t cmd;
	iss_pkg::sts_t sts;

	iss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	iss_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.mode            (in_ch.mode),
		.record_key      (in_ch.record_key),
		.record_price    (in_ch.record_price),
		.title_low       (in_ch.title_low),
		.title_high      (in_ch.title_high),
		.status          (out_ch.status),
		.found_price     (out_ch.found_price),
		.found_title_low (out_ch.found_title_low),
		.found_title_high(out_ch.found_title_high),
		.record_number   (out_ch.record_number)
	);

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |-> !cmd.out_load)
		else $error("result register loaded while previous result pending");

	// sequencer issues at most one datapath operation per cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.append, cmd.clear, cmd.search_start, cmd.idx_step,
			cmd.page_start, cmd.rec_step}))
		else $error("conflicting datapath commands");

	// a request transfer is followed by busy
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("request taken while previous one still in work");

	// a hit is only reported on a live, matching page entry
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_set && (cmd.res_code == iss_pkg::ST_FOUND) |-> sts.rec_more && sts.rec_hit)
		else $error("found reported outside the page scan window");

endmodule
